// ===== rtl/elevator_plant_emulator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the elevator plant emulator
// Both expect clk and arst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef ELEVATOR_PLANT_EMULATOR_UNIT_ASSERT_SVH
`define ELEVATOR_PLANT_EMULATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define EPE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epe assertion failed");

// next-cycle implication
`define EPE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("epe assertion failed");

`endif

// ===== rtl/epe_pkg.sv =====
// ---------------------------------------------------------------------------
// epe_pkg
// Types, codes and constants shared by the elevator plant emulator.
// ---------------------------------------------------------------------------
`default_nettype none

package epe_pkg;

	localparam int FULL_SCALE = 1000;

	localparam int POS_W      = 10;
	localparam int STEP_W     = 10;
	localparam int CMD_W      = 4;
	localparam int CODE_W     = 5;
	localparam int EVT_N      = 19;
	localparam int LATCH_N    = 11;
	localparam int SENS_N     = 6;
	localparam int LVL_N      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [POS_W-1:0] FULL_POS = POS_W'(FULL_SCALE);
	localparam logic [POS_W-1:0] WIN_LO   = POS_W'(FULL_SCALE / 20);
	localparam logic [POS_W-1:0] WIN_LH   = POS_W'(FULL_SCALE / 10);
	localparam logic [POS_W-1:0] WIN_UL   = POS_W'((9 * FULL_SCALE) / 10);
	localparam logic [POS_W-1:0] WIN_UH   = POS_W'((19 * FULL_SCALE) / 20);

	localparam logic [POS_W-1:0] CAB_RST  = POS_W'(FULL_SCALE / 10);
	localparam logic [POS_W-1:0] UDR_RST  = POS_W'((9 * FULL_SCALE) / 10);
	localparam logic [POS_W-1:0] LDR_RST  = POS_W'(FULL_SCALE / 10);

	// sensor latch bits
	localparam int S_CL  = 0;
	localparam int S_CU  = 1;
	localparam int S_UDO = 2;
	localparam int S_UDC = 3;
	localparam int S_LDO = 4;
	localparam int S_LDC = 5;
	localparam logic [LATCH_N-1:0] LATCH_RST =
		LATCH_N'((1 << S_CL) | (1 << S_UDC) | (1 << S_LDO));

	// event codes that are not derived from a loop index
	localparam int EV_BTN0     = 12;
	localparam int EV_LBAR_BLK = 15;
	localparam int EV_LBAR_REL = 16;
	localparam int EV_UBAR_BLK = 17;
	localparam int EV_UBAR_REL = 18;

	// action codes
	localparam logic ACT_CMD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DOOR_MODE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CABIN_STEP = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DOOR_STEP  = CFG_IDX_W'(2);

	localparam logic [STEP_W-1:0] CABIN_STEP_RST = STEP_W'(1);
	localparam logic [STEP_W-1:0] DOOR_STEP_RST  = STEP_W'(10);

	typedef enum logic [1:0] {
		MOT_OFF = 2'd0,
		MOT_INC = 2'd1,
		MOT_DEC = 2'd2
	} motor_t;

	typedef enum logic [2:0] {
		CTL_EXT    = 3'd0,
		CTL_IDLE   = 3'd1,
		CTL_UOPEN  = 3'd2,
		CTL_UCLOSE = 3'd3,
		CTL_LOPEN  = 3'd4,
		CTL_LCLOSE = 3'd5
	} ctl_state_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CAB_STOP   = 4'd0,
		CMD_CAB_UP     = 4'd1,
		CMD_CAB_DOWN   = 4'd2,
		CMD_LDR_STOP   = 4'd3,
		CMD_LDR_OPEN   = 4'd4,
		CMD_LDR_CLOSE  = 4'd5,
		CMD_UDR_STOP   = 4'd6,
		CMD_UDR_OPEN   = 4'd7,
		CMD_UDR_CLOSE  = 4'd8,
		CMD_LLIGHT_ON  = 4'd9,
		CMD_LLIGHT_OFF = 4'd10,
		CMD_ULIGHT_ON  = 4'd11,
		CMD_ULIGHT_OFF = 4'd12
	} cmd_t;

	// fields of one accepted request
	typedef struct packed {
		logic             action;
		logic [CMD_W-1:0] command;
		logic [LVL_N-1:0] levels; // upper barrier .. cabin button
	} item_t;

	// state picture that goes with every result of a tick
	typedef struct packed {
		logic [POS_W-1:0]  cabin_position;
		logic [POS_W-1:0]  upper_door_position;
		logic [POS_W-1:0]  lower_door_position;
		logic [SENS_N-1:0] sensor_bits;
		logic [5:0]        motor_states;
		logic [1:0]        light_states;
		ctl_state_t        controller_state;
	} snap_t;

endpackage

`default_nettype wire

// ===== rtl/epe_item_if.sv =====
// ---------------------------------------------------------------------------
// epe_item_if
// Request channel: commands and ticks into the emulator.
// ---------------------------------------------------------------------------
`default_nettype none

interface epe_item_if import epe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [CMD_W-1:0] command;
	logic             cabin_button;
	logic             lower_button;
	logic             upper_button;
	logic             lower_barrier;
	logic             upper_barrier;

	modport source (
		output valid, action, command, cabin_button, lower_button, upper_button,
		       lower_barrier, upper_barrier,
		input  ready
	);
	modport sink (
		input  valid, action, command, cabin_button, lower_button, upper_button,
		       lower_barrier, upper_barrier,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/epe_result_if.sv =====
// ---------------------------------------------------------------------------
// epe_result_if
// Result channel: one event per transfer with the plant state picture.
// ---------------------------------------------------------------------------
`default_nettype none

interface epe_result_if import epe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              event_valid;
	logic [CODE_W-1:0] event_code;
	logic              last;
	logic [POS_W-1:0]  cabin_position;
	logic [POS_W-1:0]  upper_door_position;
	logic [POS_W-1:0]  lower_door_position;
	logic [SENS_N-1:0] sensor_bits;
	logic [5:0]        motor_states;
	logic [1:0]        light_states;
	logic [2:0]        controller_state;

	modport source (
		output valid, event_valid, event_code, last, cabin_position,
		       upper_door_position, lower_door_position, sensor_bits,
		       motor_states, light_states, controller_state,
		input  ready
	);
	modport sink (
		input  valid, event_valid, event_code, last, cabin_position,
		       upper_door_position, lower_door_position, sensor_bits,
		       motor_states, light_states, controller_state,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/epe_core.sv =====
// ---------------------------------------------------------------------------
// epe_core
// Plant state, config registers, door controller and per-tick update.
// ---------------------------------------------------------------------------
`default_nettype none

module epe_core import epe_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  take,
	input  wire item_t                 item_in,
	output logic                       load,
	output logic [EVT_N-1:0]           mask,
	output snap_t                      snap
);

	logic              door_mode_q;
	logic [STEP_W-1:0] cabin_step_q;
	logic [STEP_W-1:0] door_step_q;

	logic [POS_W-1:0]   cab_pos_q, udr_pos_q, ldr_pos_q;
	motor_t             cab_mot_q, udr_mot_q, ldr_mot_q;
	logic [1:0]         light_q;
	ctl_state_t         ctl_q;
	logic [LATCH_N-1:0] latch_q;

	ctl_state_t         ctl_d;
	motor_t             udr_mot_d, ldr_mot_d;
	logic               free_ctl;
	logic [POS_W-1:0]   cab_pos_d, udr_pos_d, ldr_pos_d;
	logic [SENS_N-1:0]  win;
	logic [LATCH_N-1:0] latch_d;
	logic [LVL_N-1:0]   lvl;

	function automatic logic [POS_W-1:0] move_pos(
		input logic [POS_W-1:0]  pos,
		input motor_t            dir,
		input logic [STEP_W-1:0] step
	);
		logic [POS_W:0]   sum;
		logic [POS_W-1:0] res;
		sum = {1'b0, pos} + (POS_W+1)'(step);
		res = pos;
		case (dir)
			MOT_INC: res = (sum > {1'b0, FULL_POS}) ? FULL_POS : sum[POS_W-1:0];
			MOT_DEC: res = (pos > POS_W'(step)) ? pos - POS_W'(step) : '0;
			default: res = pos;
		endcase
		return res;
	endfunction

	function automatic logic in_win(
		input logic [POS_W-1:0] pos,
		input logic [POS_W-1:0] lo,
		input logic [POS_W-1:0] hi
	);
		return (pos >= lo) && (pos <= hi);
	endfunction

	// door controller next state, checks run in order against old latches
	always_comb begin
		ctl_d     = ctl_q;
		udr_mot_d = udr_mot_q;
		ldr_mot_d = ldr_mot_q;
		if (ctl_d == CTL_IDLE && cab_mot_q == MOT_OFF && latch_q[S_CU] && latch_q[S_UDC]) begin
			ctl_d     = CTL_UOPEN;
			udr_mot_d = MOT_DEC;
		end
		if (ctl_d == CTL_UOPEN && latch_q[S_UDO]) begin
			ctl_d     = CTL_IDLE;
			udr_mot_d = MOT_OFF;
		end
		if (ctl_d == CTL_IDLE && cab_mot_q != MOT_OFF && latch_q[S_CU] && latch_q[S_UDO]) begin
			ctl_d     = CTL_UCLOSE;
			udr_mot_d = MOT_INC;
		end
		if (ctl_d == CTL_UCLOSE && latch_q[S_UDC]) begin
			ctl_d     = CTL_IDLE;
			udr_mot_d = MOT_OFF;
		end
		if (ctl_d == CTL_IDLE && cab_mot_q == MOT_OFF && latch_q[S_CL] && latch_q[S_LDC]) begin
			ctl_d     = CTL_LOPEN;
			ldr_mot_d = MOT_DEC;
		end
		if (ctl_d == CTL_LOPEN && latch_q[S_LDO]) begin
			ctl_d     = CTL_IDLE;
			ldr_mot_d = MOT_OFF;
		end
		if (ctl_d == CTL_IDLE && cab_mot_q != MOT_OFF && latch_q[S_CL] && latch_q[S_LDO]) begin
			ctl_d     = CTL_LCLOSE;
			ldr_mot_d = MOT_INC;
		end
		if (ctl_d == CTL_LCLOSE && latch_q[S_LDC]) begin
			ctl_d     = CTL_IDLE;
			ldr_mot_d = MOT_OFF;
		end
	end

	// controller output: cabin may move only when no door is in motion by the FSM
	always_comb begin
		free_ctl = (ctl_d == CTL_EXT) || (ctl_d == CTL_IDLE);
	end

	assign cab_pos_d = free_ctl ? move_pos(cab_pos_q, cab_mot_q, cabin_step_q) : cab_pos_q;
	assign udr_pos_d = move_pos(udr_pos_q, udr_mot_d, door_step_q);
	assign ldr_pos_d = move_pos(ldr_pos_q, ldr_mot_d, door_step_q);

	assign win[S_CL]  = in_win(cab_pos_d, WIN_LO, WIN_LH);
	assign win[S_CU]  = in_win(cab_pos_d, WIN_UL, WIN_UH);
	assign win[S_UDO] = in_win(udr_pos_d, WIN_LO, WIN_LH);
	assign win[S_UDC] = in_win(udr_pos_d, WIN_UL, WIN_UH);
	assign win[S_LDO] = in_win(ldr_pos_d, WIN_LO, WIN_LH);
	assign win[S_LDC] = in_win(ldr_pos_d, WIN_UL, WIN_UH);

	assign lvl     = item_in.levels;
	assign latch_d = {lvl, win};

	always_comb begin
		mask = '0;
		for (int i = 0; i < SENS_N; i++) begin
			// cabin arrivals are swallowed while a door is busy
			mask[2*i]   = win[i] && !latch_q[i] && ((i >= 2) || free_ctl);
			mask[2*i+1] = !win[i] && latch_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			mask[EV_BTN0+i] = lvl[i] && !latch_q[SENS_N+i];
		end
		mask[EV_LBAR_BLK] = lvl[3] && !latch_q[SENS_N+3];
		mask[EV_LBAR_REL] = !lvl[3] && latch_q[SENS_N+3];
		mask[EV_UBAR_BLK] = lvl[4] && !latch_q[SENS_N+4];
		mask[EV_UBAR_REL] = !lvl[4] && latch_q[SENS_N+4];
	end

	assign load = take && (item_in.action == ACT_TICK);

	assign snap.cabin_position      = cab_pos_d;
	assign snap.upper_door_position = udr_pos_d;
	assign snap.lower_door_position = ldr_pos_d;
	assign snap.sensor_bits         = win;
	assign snap.motor_states        = {ldr_mot_d, udr_mot_d, cab_mot_q};
	assign snap.light_states        = light_q;
	assign snap.controller_state    = ctl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_mode_q  <= 1'b0;
			cabin_step_q <= CABIN_STEP_RST;
			door_step_q  <= DOOR_STEP_RST;
			cab_pos_q    <= CAB_RST;
			udr_pos_q    <= UDR_RST;
			ldr_pos_q    <= LDR_RST;
			cab_mot_q    <= MOT_OFF;
			udr_mot_q    <= MOT_OFF;
			ldr_mot_q    <= MOT_OFF;
			light_q      <= '0;
			ctl_q        <= CTL_IDLE;
			latch_q      <= LATCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DOOR_MODE: begin
					// a mode change restarts the whole plant
					if (cfg_data[0] != door_mode_q) begin
						door_mode_q <= cfg_data[0];
						cab_pos_q   <= CAB_RST;
						udr_pos_q   <= UDR_RST;
						ldr_pos_q   <= LDR_RST;
						cab_mot_q   <= MOT_OFF;
						udr_mot_q   <= MOT_OFF;
						ldr_mot_q   <= MOT_OFF;
						light_q     <= '0;
						ctl_q       <= cfg_data[0] ? CTL_EXT : CTL_IDLE;
						latch_q     <= LATCH_RST;
					end
				end
				REG_CABIN_STEP: cabin_step_q <= cfg_data[STEP_W-1:0];
				REG_DOOR_STEP:  door_step_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end else if (load) begin
			cab_pos_q <= cab_pos_d;
			udr_pos_q <= udr_pos_d;
			ldr_pos_q <= ldr_pos_d;
			udr_mot_q <= udr_mot_d;
			ldr_mot_q <= ldr_mot_d;
			ctl_q     <= ctl_d;
			latch_q   <= latch_d;
		end else if (take) begin
			case (cmd_t'(item_in.command))
				CMD_CAB_STOP:   cab_mot_q  <= MOT_OFF;
				CMD_CAB_UP:     cab_mot_q  <= MOT_INC;
				CMD_CAB_DOWN:   cab_mot_q  <= MOT_DEC;
				CMD_LDR_STOP:   ldr_mot_q  <= MOT_OFF;
				CMD_LDR_OPEN:   ldr_mot_q  <= MOT_DEC;
				CMD_LDR_CLOSE:  ldr_mot_q  <= MOT_INC;
				CMD_UDR_STOP:   udr_mot_q  <= MOT_OFF;
				CMD_UDR_OPEN:   udr_mot_q  <= MOT_DEC;
				CMD_UDR_CLOSE:  udr_mot_q  <= MOT_INC;
				CMD_LLIGHT_ON:  light_q[0] <= 1'b1;
				CMD_LLIGHT_OFF: light_q[0] <= 1'b0;
				CMD_ULIGHT_ON:  light_q[1] <= 1'b1;
				CMD_ULIGHT_OFF: light_q[1] <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/epe_emit.sv =====
// ---------------------------------------------------------------------------
// epe_emit
// Result register: holds one tick's event mask and sends events in order.
// ---------------------------------------------------------------------------
`default_nettype none

module epe_emit import epe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [EVT_N-1:0] mask_in,
	input  wire snap_t            snap_in,
	output logic                  free,
	epe_result_if.source          result
);

	logic [EVT_N-1:0]  mask_q;
	snap_t             snap_q;
	logic              busy_q;
	logic [EVT_N-1:0]  low_bit;
	logic [EVT_N-1:0]  rest;
	logic              last;
	logic              pop;
	logic [CODE_W-1:0] code;

	// lowest pending event goes first
	assign low_bit = mask_q & (~mask_q + EVT_N'(1));
	assign rest    = mask_q & ~low_bit;
	assign last    = (rest == '0);
	assign pop     = busy_q && result.ready;
	assign free    = !busy_q || (pop && last);

	always_comb begin
		code = '0;
		for (int i = EVT_N - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				code = CODE_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (pop && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mask_q <= mask_in;
			snap_q <= snap_in;
		end else if (pop) begin
			mask_q <= rest;
		end
	end

	assign result.valid               = busy_q;
	assign result.event_valid         = (mask_q != '0);
	assign result.event_code          = code;
	assign result.last                = last;
	assign result.cabin_position      = snap_q.cabin_position;
	assign result.upper_door_position = snap_q.upper_door_position;
	assign result.lower_door_position = snap_q.lower_door_position;
	assign result.sensor_bits         = snap_q.sensor_bits;
	assign result.motor_states        = snap_q.motor_states;
	assign result.light_states        = snap_q.light_states;
	assign result.controller_state    = snap_q.controller_state;

endmodule

`default_nettype wire

// ===== rtl/elevator_plant_emulator_unit.sv =====
// ---------------------------------------------------------------------------
// elevator_plant_emulator_unit
// Two-floor elevator plant: motors, doors, sensors and coded sensor events.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake        | carries
//  item     | in  | valid / ready    | action, command, button and barrier levels
//  result   | out | valid / ready    | event, last, positions, sensors, motors
//  cfg      | in  | cfg_we           | cfg_index, cfg_data (door_mode, steps)
//
// A tick request updates the plant in the cycle it is taken and loads the
// result register; it then leaves one result per event, or a single result
// with no event if there is none. A command request leaves no result.
// item.ready is low only while the result register still holds a tick whose
// last result is not being taken, so result stalls back up to the input.
// Reset is asynchronous; there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "elevator_plant_emulator_unit_assert.svh"

module elevator_plant_emulator_unit import epe_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	epe_item_if.sink                   item,
	epe_result_if.source               result
);

	logic             take;
	logic             load;
	logic             free;
	logic [EVT_N-1:0] mask;
	snap_t            snap;
	item_t            item_in;

	assign item.ready = free;
	assign take       = item.valid && free;

	assign item_in.action  = item.action;
	assign item_in.command = item.command;
	assign item_in.levels  = {item.upper_barrier, item.lower_barrier, item.upper_button,
	                          item.lower_button, item.cabin_button};

	epe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item_in   (item_in),
		.load      (load),
		.mask      (mask),
		.snap      (snap)
	);

	epe_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.mask_in (mask),
		.snap_in (snap),
		.free    (free),
		.result  (result)
	);

	`EPE_ASSERT_IMP(a_quiet_is_last, result.valid && !result.event_valid, result.last)
	`EPE_ASSERT_NXT(a_tick_gives_result,
		item.valid && item.ready && item.action == ACT_TICK, result.valid)
	`EPE_ASSERT_IMP(a_ready_when_empty, !result.valid, item.ready)
	`EPE_ASSERT_IMP(a_cabin_in_range, result.valid, result.cabin_position <= FULL_POS)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - elevator plant emulator testbench
// Drives command and tick requests with random gaps, mirrors the plant in a
// local predictor (motors, doors, door controller, sensor latches) and checks
// every result event and state picture in order. Covers built-in and external
// door control, step extremes and a long result stall.
// ---------------------------------------------------------------------------
module tb;
	import epe_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_REPORTS    = 40;

	// event codes
	localparam int EV_CAB_LO_ARR    = 0;
	localparam int EV_CAB_LO_LEAVE  = 1;
	localparam int EV_CAB_UP_ARR    = 2;
	localparam int EV_CAB_UP_LEAVE  = 3;
	localparam int EV_UDR_OPEN_ARR  = 4;
	localparam int EV_UDR_OPEN_LV   = 5;
	localparam int EV_UDR_SHUT_ARR  = 6;
	localparam int EV_UDR_SHUT_LV   = 7;
	localparam int EV_LDR_OPEN_ARR  = 8;
	localparam int EV_LDR_OPEN_LV   = 9;
	localparam int EV_LDR_SHUT_ARR  = 10;
	localparam int EV_LDR_SHUT_LV   = 11;
	localparam int EV_CAB_BTN       = EV_BTN0;
	localparam int EV_LOW_BTN       = EV_BTN0 + 1;
	localparam int EV_UPP_BTN       = EV_BTN0 + 2;

	// level positions in the request and their latch bits
	localparam int LV_CAB_BTN = 0;
	localparam int LV_LOW_BTN = 1;
	localparam int LV_UPP_BTN = 2;
	localparam int LV_LOW_BAR = 3;
	localparam int LV_UPP_BAR = 4;
	localparam int L_CAB_BTN  = SENS_N + LV_CAB_BTN;
	localparam int L_LOW_BTN  = SENS_N + LV_LOW_BTN;
	localparam int L_UPP_BTN  = SENS_N + LV_UPP_BTN;
	localparam int L_LOW_BAR  = SENS_N + LV_LOW_BAR;
	localparam int L_UPP_BAR  = SENS_N + LV_UPP_BAR;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	typedef struct packed {
		logic              ev_valid;
		logic [CODE_W-1:0] ev_code;
		logic              last;
		snap_t             snap;
	} event_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	epe_item_if   item_ch ();
	epe_result_if res_ch ();

	elevator_plant_emulator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted plant
	logic               door_ext;
	logic [STEP_W-1:0]  cab_step_r;
	logic [STEP_W-1:0]  door_step_r;
	logic [POS_W-1:0]   cab_pos;
	logic [POS_W-1:0]   udr_pos;
	logic [POS_W-1:0]   ldr_pos;
	motor_t             cab_mot;
	motor_t             udr_mot;
	motor_t             ldr_mot;
	logic               llight;
	logic               ulight;
	ctl_state_t         door_ctl;
	logic [LATCH_N-1:0] seen;
	logic [EVT_N-1:0]   ev_mask;

	event_report_t plant_reports[$];

	logic [LVL_N-1:0] lvl = '0;
	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;
	int mismatches = 0;
	int n_ticks = 0;
	int n_cmds = 0;
	int n_events = 0;
	int n_quiet = 0;
	int quiet_cycles = 0;

	function automatic void plant_init();
		cab_pos  = CAB_RST;
		udr_pos  = UDR_RST;
		ldr_pos  = LDR_RST;
		cab_mot  = MOT_OFF;
		udr_mot  = MOT_OFF;
		ldr_mot  = MOT_OFF;
		llight   = 1'b0;
		ulight   = 1'b0;
		door_ctl = door_ext ? CTL_EXT : CTL_IDLE;
		seen     = LATCH_RST;
		ev_mask  = '0;
	endfunction

	function automatic void plant_write_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_DOOR_MODE: begin
				// only a change of mode restarts the plant
				if (val[0] != door_ext) begin
					door_ext = val[0];
					plant_init();
				end
			end
			REG_CABIN_STEP: cab_step_r  = val;
			REG_DOOR_STEP:  door_step_r = val;
			default: ;
		endcase
	endfunction

	function automatic void plant_command(logic [CMD_W-1:0] c);
		n_cmds++;
		case (c)
			CMD_CAB_STOP:   cab_mot = MOT_OFF;
			CMD_CAB_UP:     cab_mot = MOT_INC;
			CMD_CAB_DOWN:   cab_mot = MOT_DEC;
			CMD_LDR_STOP:   ldr_mot = MOT_OFF;
			CMD_LDR_OPEN:   ldr_mot = MOT_DEC;
			CMD_LDR_CLOSE:  ldr_mot = MOT_INC;
			CMD_UDR_STOP:   udr_mot = MOT_OFF;
			CMD_UDR_OPEN:   udr_mot = MOT_DEC;
			CMD_UDR_CLOSE:  udr_mot = MOT_INC;
			CMD_LLIGHT_ON:  llight = 1'b1;
			CMD_LLIGHT_OFF: llight = 1'b0;
			CMD_ULIGHT_ON:  ulight = 1'b1;
			CMD_ULIGHT_OFF: ulight = 1'b0;
			default: ;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] slide(logic [POS_W-1:0] pos, motor_t dir,
			logic [STEP_W-1:0] step);
		int unsigned p;
		p = pos;
		if (dir == MOT_INC) begin
			p = p + step;
			if (p > FULL_SCALE)
				p = FULL_SCALE;
		end else if (dir == MOT_DEC) begin
			p = (p > step) ? p - step : 0;
		end
		return POS_W'(p);
	endfunction

	function automatic void door_controller();
		if (door_ctl == CTL_EXT)
			return;
		if (door_ctl == CTL_IDLE && cab_mot == MOT_OFF && seen[S_CU] && seen[S_UDC]) begin
			door_ctl = CTL_UOPEN;
			udr_mot  = MOT_DEC;
		end
		if (door_ctl == CTL_UOPEN && seen[S_UDO]) begin
			door_ctl = CTL_IDLE;
			udr_mot  = MOT_OFF;
		end
		if (door_ctl == CTL_IDLE && cab_mot != MOT_OFF && seen[S_CU] && seen[S_UDO]) begin
			door_ctl = CTL_UCLOSE;
			udr_mot  = MOT_INC;
		end
		if (door_ctl == CTL_UCLOSE && seen[S_UDC]) begin
			door_ctl = CTL_IDLE;
			udr_mot  = MOT_OFF;
		end
		if (door_ctl == CTL_IDLE && cab_mot == MOT_OFF && seen[S_CL] && seen[S_LDC]) begin
			door_ctl = CTL_LOPEN;
			ldr_mot  = MOT_DEC;
		end
		if (door_ctl == CTL_LOPEN && seen[S_LDO]) begin
			door_ctl = CTL_IDLE;
			ldr_mot  = MOT_OFF;
		end
		if (door_ctl == CTL_IDLE && cab_mot != MOT_OFF && seen[S_CL] && seen[S_LDO]) begin
			door_ctl = CTL_LCLOSE;
			ldr_mot  = MOT_INC;
		end
		if (door_ctl == CTL_LCLOSE && seen[S_LDC]) begin
			door_ctl = CTL_IDLE;
			ldr_mot  = MOT_OFF;
		end
	endfunction

	function automatic void sense_window(logic [POS_W-1:0] pos, logic [POS_W-1:0] lo,
			logic [POS_W-1:0] hi, int bit_i, int arrive, int leave, logic allow);
		if (pos >= lo && pos <= hi) begin
			if (!seen[bit_i] && allow)
				ev_mask[arrive] = 1'b1;
			seen[bit_i] = 1'b1;
		end else begin
			if (seen[bit_i])
				ev_mask[leave] = 1'b1;
			seen[bit_i] = 1'b0;
		end
	endfunction

	function automatic void level_change(logic level, int bit_i, int rise, int fall,
			logic has_fall);
		if (level) begin
			if (!seen[bit_i])
				ev_mask[rise] = 1'b1;
			seen[bit_i] = 1'b1;
		end else begin
			if (seen[bit_i] && has_fall)
				ev_mask[fall] = 1'b1;
			seen[bit_i] = 1'b0;
		end
	endfunction

	function automatic void plant_tick(item_t it);
		logic          free_cab;
		snap_t         pic;
		event_report_t rep;
		int            top;
		int            c;
		n_ticks++;
		door_controller();
		// cabin is held while a door is being driven by the controller
		free_cab = (door_ctl == CTL_EXT) || (door_ctl == CTL_IDLE);
		if (free_cab)
			cab_pos = slide(cab_pos, cab_mot, cab_step_r);
		udr_pos = slide(udr_pos, udr_mot, door_step_r);
		ldr_pos = slide(ldr_pos, ldr_mot, door_step_r);

		ev_mask = '0;
		sense_window(cab_pos, WIN_LO, WIN_LH, S_CL, EV_CAB_LO_ARR, EV_CAB_LO_LEAVE, free_cab);
		sense_window(cab_pos, WIN_UL, WIN_UH, S_CU, EV_CAB_UP_ARR, EV_CAB_UP_LEAVE, free_cab);
		sense_window(udr_pos, WIN_LO, WIN_LH, S_UDO, EV_UDR_OPEN_ARR, EV_UDR_OPEN_LV, 1'b1);
		sense_window(udr_pos, WIN_UL, WIN_UH, S_UDC, EV_UDR_SHUT_ARR, EV_UDR_SHUT_LV, 1'b1);
		sense_window(ldr_pos, WIN_LO, WIN_LH, S_LDO, EV_LDR_OPEN_ARR, EV_LDR_OPEN_LV, 1'b1);
		sense_window(ldr_pos, WIN_UL, WIN_UH, S_LDC, EV_LDR_SHUT_ARR, EV_LDR_SHUT_LV, 1'b1);
		level_change(it.levels[LV_CAB_BTN], L_CAB_BTN, EV_CAB_BTN, 0, 1'b0);
		level_change(it.levels[LV_LOW_BTN], L_LOW_BTN, EV_LOW_BTN, 0, 1'b0);
		level_change(it.levels[LV_UPP_BTN], L_UPP_BTN, EV_UPP_BTN, 0, 1'b0);
		level_change(it.levels[LV_LOW_BAR], L_LOW_BAR, EV_LBAR_BLK, EV_LBAR_REL, 1'b1);
		level_change(it.levels[LV_UPP_BAR], L_UPP_BAR, EV_UBAR_BLK, EV_UBAR_REL, 1'b1);

		pic.cabin_position      = cab_pos;
		pic.upper_door_position = udr_pos;
		pic.lower_door_position = ldr_pos;
		pic.sensor_bits         = seen[SENS_N-1:0];
		pic.motor_states        = {ldr_mot, udr_mot, cab_mot};
		pic.light_states        = {ulight, llight};
		pic.controller_state    = door_ctl;

		top = -1;
		for (c = 0; c < EVT_N; c++)
			if (ev_mask[c])
				top = c;
		rep.snap = pic;
		if (top < 0) begin
			rep.ev_valid = 1'b0;
			rep.ev_code  = '0;
			rep.last     = 1'b1;
			plant_reports.push_back(rep);
			n_quiet++;
		end else begin
			for (c = 0; c < EVT_N; c++) begin
				if (ev_mask[c]) begin
					rep.ev_valid = 1'b1;
					rep.ev_code  = CODE_W'(c);
					rep.last     = (c == top);
					plant_reports.push_back(rep);
					n_events++;
				end
			end
		end
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic item_t cmd_req(logic [CMD_W-1:0] c);
		item_t it;
		it.action  = ACT_CMD;
		it.command = c;
		it.levels  = LVL_N'($urandom());
		return it;
	endfunction

	function automatic item_t tick_req(logic [LVL_N-1:0] lv);
		item_t it;
		it.action  = ACT_TICK;
		it.command = CMD_W'($urandom());
		it.levels  = lv;
		return it;
	endfunction

	function automatic logic [LVL_N-1:0] next_levels();
		for (int b = 0; b < LVL_N; b++)
			if ($urandom_range(0, 7) == 0)
				lvl[b] = ~lvl[b];
		return lvl;
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(bit ext);
		int r;
		r = $urandom_range(0, 99);
		if (ext && r < 35)
			return CMD_W'($urandom_range(CMD_LDR_STOP, CMD_UDR_CLOSE));
		if (r < 80)
			return CMD_W'($urandom_range(CMD_CAB_STOP, CMD_CAB_DOWN));
		return CMD_W'($urandom_range(CMD_LLIGHT_ON, CMD_ULIGHT_OFF));
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.action        <= it.action;
		item_ch.command       <= it.command;
		item_ch.cabin_button  <= it.levels[LV_CAB_BTN];
		item_ch.lower_button  <= it.levels[LV_LOW_BTN];
		item_ch.upper_button  <= it.levels[LV_UPP_BTN];
		item_ch.lower_barrier <= it.levels[LV_LOW_BAR];
		item_ch.upper_barrier <= it.levels[LV_UPP_BAR];
		@(posedge clk);
		while (!(item_ch.valid === 1'b1 && item_ch.ready === 1'b1))
			@(posedge clk);
		if (it.action == ACT_TICK)
			plant_tick(it);
		else
			plant_command(it.command);
	endtask

	// let every expected result come back before touching registers
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (plant_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		plant_write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly a command followed by a burst of ticks, some fully random requests
	task automatic run_traffic(int n, bit ext);
		int sent;
		int k;
		item_t it;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 20) begin
				it.action  = 1'($urandom_range(0, 1));
				it.command = CMD_W'($urandom());
				it.levels  = LVL_N'($urandom());
				send_item(it);
				sent++;
			end else begin
				send_item(cmd_req(pick_cmd(ext)));
				sent++;
				k = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
				repeat (k) begin
					send_item(tick_req(next_levels()));
					sent++;
				end
			end
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_sensor_levels();
		send_item(tick_req('0));
		send_item(tick_req('1));
		send_item(tick_req('0));
		lvl = '0;
	endtask

	task automatic test_lights_and_spare_codes();
		send_item(cmd_req(CMD_LLIGHT_ON));
		send_item(cmd_req(CMD_ULIGHT_ON));
		for (int c = CMD_ULIGHT_OFF + 1; c < (1 << CMD_W); c++)
			send_item(cmd_req(CMD_W'(c)));
		send_item(tick_req(lvl));
		send_item(cmd_req(CMD_LLIGHT_OFF));
		send_item(cmd_req(CMD_ULIGHT_OFF));
		send_item(tick_req(lvl));
	endtask

	task automatic test_external_full_steps();
		settle();
		write_reg(REG_DOOR_MODE, CFG_DATA_W'(1));
		write_reg(REG_CABIN_STEP, CFG_DATA_W'(FULL_POS));
		write_reg(REG_DOOR_STEP, CFG_DATA_W'(FULL_POS));
		send_item(cmd_req(CMD_LDR_CLOSE));
		send_item(cmd_req(CMD_UDR_OPEN));
		send_item(cmd_req(CMD_CAB_UP));
		send_item(tick_req(lvl));
		send_item(cmd_req(CMD_LDR_OPEN));
		send_item(cmd_req(CMD_UDR_CLOSE));
		send_item(cmd_req(CMD_CAB_DOWN));
		send_item(tick_req(lvl));
		send_item(cmd_req(CMD_CAB_STOP));
		send_item(cmd_req(CMD_LDR_STOP));
		send_item(cmd_req(CMD_UDR_STOP));
		send_item(tick_req(lvl));
	endtask

	task automatic test_builtin_doors();
		settle();
		write_reg(REG_DOOR_MODE, CFG_DATA_W'(0));
		write_reg(REG_CABIN_STEP, CFG_DATA_W'(40));
		write_reg(REG_DOOR_STEP, CFG_DATA_W'(40));
		run_traffic(120, 1'b0);
	endtask

	task automatic test_result_backpressure();
		hold_req = 1'b1;
		run_traffic(40, 1'b0);
	endtask

	task automatic test_external_traffic();
		settle();
		write_reg(REG_DOOR_MODE, CFG_DATA_W'(1));
		write_reg(REG_CABIN_STEP, CFG_DATA_W'($urandom_range(10, 50)));
		write_reg(REG_DOOR_STEP, CFG_DATA_W'($urandom_range(10, 50)));
		run_traffic(100, 1'b1);
	endtask

	task automatic test_step_extremes();
		settle();
		write_reg(REG_CABIN_STEP, '0);
		write_reg(REG_DOOR_STEP, CFG_DATA_W'($urandom_range(1, FULL_SCALE)));
		// same mode again: plant keeps running
		write_reg(REG_DOOR_MODE, CFG_DATA_W'(1));
		run_traffic(20, 1'b1);
		settle();
		write_reg(REG_CABIN_STEP, '1);
		write_reg(REG_DOOR_STEP, '0);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
		run_traffic(20, 1'b1);
	endtask

	task automatic test_back_to_back();
		settle();
		write_reg(REG_DOOR_MODE, CFG_DATA_W'(0));
		write_reg(REG_CABIN_STEP, CFG_DATA_W'($urandom_range(5, 50)));
		write_reg(REG_DOOR_STEP, CFG_DATA_W'($urandom_range(5, 50)));
		no_idle = 1'b1;
		run_traffic(40, 1'b0);
		no_idle = 1'b0;
	endtask

	// ---------------- result side ----------------

	initial begin : result_ready_gen
		int n;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					res_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		event_report_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (plant_reports.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t ns: result with nothing expected, expected none, got code %0d",
						$time, res_ch.event_code);
				mismatches++;
			end else begin
				want = plant_reports.pop_front();
				check_field("event_valid", 32'(want.ev_valid), 32'(res_ch.event_valid));
				check_field("event_code", 32'(want.ev_code), 32'(res_ch.event_code));
				check_field("last", 32'(want.last), 32'(res_ch.last));
				check_field("cabin_position", 32'(want.snap.cabin_position),
					32'(res_ch.cabin_position));
				check_field("upper_door_position", 32'(want.snap.upper_door_position),
					32'(res_ch.upper_door_position));
				check_field("lower_door_position", 32'(want.snap.lower_door_position),
					32'(res_ch.lower_door_position));
				check_field("sensor_bits", 32'(want.snap.sensor_bits), 32'(res_ch.sensor_bits));
				check_field("motor_states", 32'(want.snap.motor_states),
					32'(res_ch.motor_states));
				check_field("light_states", 32'(want.snap.light_states),
					32'(res_ch.light_states));
				check_field("controller_state", 32'(want.snap.controller_state),
					32'(res_ch.controller_state));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no request or result moved for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, plant_reports.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		item_ch.valid         <= 1'b0;
		item_ch.action        <= ACT_CMD;
		item_ch.command       <= '0;
		item_ch.cabin_button  <= 1'b0;
		item_ch.lower_button  <= 1'b0;
		item_ch.upper_button  <= 1'b0;
		item_ch.lower_barrier <= 1'b0;
		item_ch.upper_barrier <= 1'b0;
		door_ext    = 1'b0;
		cab_step_r  = CABIN_STEP_RST;
		door_step_r = DOOR_STEP_RST;
		plant_init();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sensor_levels();
		test_lights_and_spare_codes();
		test_external_full_steps();
		test_builtin_doors();
		test_result_backpressure();
		test_external_traffic();
		test_step_extremes();
		test_back_to_back();
		settle();

		$display("Run covered %0d ticks and %0d commands, %0d sensor events and %0d quiet ticks.",
			n_ticks, n_cmds, n_events, n_quiet);
		$display("Built-in and external door control, steps 0 to 1023, one long result stall.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/epe_pkg.sv
rtl/epe_item_if.sv
rtl/epe_result_if.sv
rtl/epe_core.sv
rtl/epe_emit.sv
rtl/elevator_plant_emulator_unit.sv
verif/tb.sv
